// ===== design/m3wh_pkg.sv =====
// Package: constants, types and helpers shared by the word hash modules.
`default_nettype none
package m3wh_pkg;

  localparam logic [31:0] MIX_K1    = 32'hCC9E2D51;
  localparam logic [31:0] MIX_K2    = 32'h1B873593;
  localparam logic [31:0] CHAIN_K   = 32'hE6546B64;
  localparam logic [31:0] FIN_K1    = 32'h85EBCA6B;
  localparam logic [31:0] FIN_K2    = 32'hC2B2AE35;
  localparam logic [31:0] SEED_MULT_RST = 32'h9E3779B9;

  localparam logic [2:0] FULL_WORD = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MIX1,
    ST_MIX2,
    ST_CHAIN,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } state_t;

  typedef enum logic [2:0] {
    MUL_SEED,
    MUL_K1,
    MUL_K2,
    MUL_F1,
    MUL_F2
  } mul_op_t;

  typedef struct packed {
    logic    accept;
    logic    load_len;
    logic    mul_en;
    mul_op_t mul_op;
    logic    chain_en;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } status_t;

  // byte counts above four count as a full word
  function automatic logic [2:0] clamp_count(input logic [2:0] cnt);
    logic [2:0] res;
    begin
      res = (cnt > FULL_WORD) ? FULL_WORD : cnt;
      return res;
    end
  endfunction

  // keep only the valid low bytes of a tail word
  function automatic logic [31:0] mask_word(input logic [31:0] word, input logic [2:0] cnt);
    logic [31:0] res;
    begin
      case (cnt)
        3'd0:    res = 32'h0000_0000;
        3'd1:    res = word & 32'h0000_00FF;
        3'd2:    res = word & 32'h0000_FFFF;
        3'd3:    res = word & 32'h00FF_FFFF;
        default: res = word;
      endcase
      return res;
    end
  endfunction

endpackage : m3wh_pkg
`default_nettype wire

// ===== design/m3wh_ctrl.sv =====
// Controller: sequences accept, seeding, word mixing, chaining and finalising.
`default_nettype none
module m3wh_ctrl
  import m3wh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_tvalid,
  output logic         in_tready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;
  logic   inside_r, inside_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      inside_r <= inside_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    inside_nxt = inside_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = inside_r ? ST_MIX1 : ST_SEED;
        end
      end
      ST_SEED:  state_nxt = ST_MIX1;
      ST_MIX1:  state_nxt = ST_MIX2;
      ST_MIX2:  state_nxt = ST_CHAIN;
      ST_CHAIN: begin
        inside_nxt = !status.last;
        state_nxt  = status.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1:  state_nxt = ST_FIN2;
      ST_FIN2:  state_nxt = ST_FIN3;
      ST_FIN3: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs; no transfer is taken while reset is held
  always_comb begin
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.mul_op   = MUL_K1;
    case (state_r)
      ST_IDLE: begin
        in_tready    = rst_n;
        cmd.accept   = in_tvalid && rst_n;
        cmd.load_len = in_tvalid && rst_n && !inside_r;
      end
      ST_SEED: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SEED;
      end
      ST_MIX1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_K1;
      end
      ST_MIX2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_K2;
      end
      ST_CHAIN: cmd.chain_en = 1'b1;
      ST_FIN1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_F1;
      end
      ST_FIN2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_F2;
      end
      ST_FIN3:  cmd.emit = status.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule : m3wh_ctrl
`default_nettype wire

// ===== design/m3wh_dpath.sv =====
// Datapath: input registers, shared 32x32 multiplier, hash chain and output register.
`default_nettype none
module m3wh_dpath
  import m3wh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [31:0] in_word,
  input  wire logic [2:0]  in_count,
  input  wire logic        in_last,
  input  wire logic [31:0] in_length,
  input  wire logic        cfg_valid,
  input  wire logic [31:0] cfg_data,
  input  wire cmd_t        cmd,
  output status_t          status,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_hash
);

  logic [31:0] seed_r;
  logic [31:0] word_r;
  logic [2:0]  cnt_r;
  logic        last_r;
  logic [31:0] len_r;
  logic [31:0] hash_r, hash_nxt;
  logic [31:0] prod_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [31:0] mul_a, mul_b, product;
  logic [31:0] fin_in;
  logic [31:0] chain_x, chain_rot;
  logic [31:0] final_val;
  logic [2:0]  cnt_clamped;

  assign cnt_clamped = clamp_count(in_count);
  assign fin_in      = hash_r ^ len_r;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.mul_op)
      MUL_SEED: begin
        mul_a = len_r;
        mul_b = seed_r;
      end
      MUL_K1: begin
        mul_a = word_r;
        mul_b = MIX_K1;
      end
      MUL_K2: begin
        mul_a = {prod_r[16:0], prod_r[31:17]};
        mul_b = MIX_K2;
      end
      MUL_F1: begin
        mul_a = fin_in ^ {16'h0000, fin_in[31:16]};
        mul_b = FIN_K1;
      end
      MUL_F2: begin
        mul_a = prod_r ^ {13'h0000, prod_r[31:13]};
        mul_b = FIN_K2;
      end
      default: begin
        mul_a = word_r;
        mul_b = MIX_K1;
      end
    endcase
  end

  assign product = mul_a * mul_b;

  // chain update: xor in the mixed word; full words rotate, *5 + k; empty words skip
  always_comb begin
    chain_x   = hash_r ^ prod_r;
    chain_rot = {chain_x[18:0], chain_x[31:19]};
    if (cnt_r == FULL_WORD) begin
      hash_nxt = chain_rot + {chain_rot[29:0], 2'b00} + CHAIN_K;
    end else if (cnt_r != 3'd0) begin
      hash_nxt = chain_x;
    end else begin
      hash_nxt = hash_r;
    end
  end

  assign final_val = (len_r == 32'h0) ? 32'h0 : (prod_r ^ {16'h0000, prod_r[31:16]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= SEED_MULT_RST;
    end else if (cfg_valid) begin
      seed_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= 32'h0;
      len_r  <= 32'h0;
    end else begin
      if (cmd.load_len) begin
        len_r <= in_length;
      end
      if (cmd.mul_en && (cmd.mul_op == MUL_SEED)) begin
        hash_r <= product;
      end else if (cmd.chain_en) begin
        hash_r <= hash_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r <= mask_word(in_word, cnt_clamped);
      cnt_r  <= cnt_clamped;
      last_r <= in_last;
    end
    if (cmd.mul_en && (cmd.mul_op != MUL_SEED)) begin
      prod_r <= product;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= final_val;
    end
  end

  assign status.last     = last_r;
  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_hash        = out_data_r;

endmodule : m3wh_dpath
`default_nettype wire

// ===== design/murmur3_word_hash.sv =====
// Top level: streaming 32-bit Murmur3 word hash.
//
// Channels:
//   in_*  : one message word per transfer. tdata carries data_word, byte_count and
//           message_length; tlast marks the final word of a message.
//   out_* : one transfer per message carrying the finalised 32-bit hash.
//   cfg_* : write of the seed multiplier; ready whenever out of reset. Write only while idle.
// Sequence: a word is taken in ST_IDLE, then mixed through a single shared
//   32x32 multiplier (two multiplies) and chained; the first word of a
//   message first passes ST_SEED (length * multiplier seeds the chain). The last
//   word then passes ST_FIN1, ST_FIN2 and ST_FIN3 (two more multiplies) before
//   the hash is registered in the output register.
//   Throughput is bound by the one multiplier being reused for every multiply.
// Reset (synchronous, rst_n low): controller idles, chain and length clear,
//   multiplier returns to 0x9E3779B9, output register empties; no transfer taken.
// Stall: a finished hash waits in the output register; new words are accepted
//   meanwhile, and the next result holds in the last finalising step until
//   the output register frees.
// An empty message (length zero) hashes to 0.
`default_nettype none
module murmur3_word_hash
  import m3wh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // [31:0] data_word, [34:32] byte_count,
                                       // [66:35] message_length, [71:67] zero
  input  wire logic        in_tlast,   // last_word
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] hash_value
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data    // seed_multiplier
);

  cmd_t    cmd;
  status_t status;

  // register writes are taken whenever out of reset
  assign cfg_ready = rst_n;

  m3wh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  m3wh_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_tdata[31:0]),
    .in_count   (in_tdata[34:32]),
    .in_last    (in_tlast),
    .in_length  (in_tdata[66:35]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_hash   (out_tdata)
  );

endmodule : murmur3_word_hash
`default_nettype wire
